FILE: hdl/unsigned_to_decimal_ascii_assert.svh
// Assertion macros used by the checker of the decimal ASCII converter.
`ifndef UNSIGNED_TO_DECIMAL_ASCII_ASSERT_SVH
`define UNSIGNED_TO_DECIMAL_ASCII_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define U2DA_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
		else $error("%m: invariant violated");

// When the antecedent holds, the consequent must hold in the next cycle.
`define U2DA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("%m: sequence violated");

`endif

FILE: hdl/u2da_pkg.sv
// Types, constants and conversion functions of the decimal ASCII converter.
package u2da_pkg;

	localparam int VALUE_W = 16;
	localparam int DIGITS = 5;
	localparam int NIBBLE_W = 4;
	localparam int BCD_W = DIGITS * NIBBLE_W;
	localparam int CHAR_W = 6;
	localparam int DIGIT_IDX_W = 3;
	localparam int DD_STAGES = 4;
	localparam int DD_STEPS_PER_STAGE = VALUE_W / DD_STAGES;

	localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);
	localparam logic [NIBBLE_W-1:0] DD_LIMIT = NIBBLE_W'(5);
	localparam logic [NIBBLE_W-1:0] DD_ADJUST = NIBBLE_W'(3);

	typedef logic [DIGITS-1:0][NIBBLE_W-1:0] bcd_t;
	typedef logic [DIGIT_IDX_W-1:0] digit_idx_t;

	typedef struct packed {
		bcd_t bcd;
		logic [VALUE_W-1:0] bin;
	} dd_t;

	// Several shift-and-add-3 steps of the double dabble conversion.
	function automatic dd_t dabble_steps(dd_t s);
		dd_t r;
		r = s;
		for (int step = 0; step < DD_STEPS_PER_STAGE; step++) begin
			for (int d = 0; d < DIGITS; d++) begin
				if (r.bcd[d] >= DD_LIMIT) begin
					r.bcd[d] = r.bcd[d] + DD_ADJUST;
				end
			end
			r = {r[$bits(dd_t)-2:0], 1'b0};
		end
		return r;
	endfunction

	// Position of the most significant nonzero digit; zero for the value zero.
	function automatic digit_idx_t top_digit_index(bcd_t b);
		digit_idx_t idx;
		idx = '0;
		for (int i = 1; i < DIGITS; i++) begin
			if (b[i] != '0) begin
				idx = DIGIT_IDX_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

FILE: hdl/u2da_channels.sv
// Channel interfaces for numbers in and characters out.
interface u2da_num_if;
	import u2da_pkg::*;
	logic valid;
	logic ready;
	logic [VALUE_W-1:0] value;
	modport source(output valid, output value, input ready);
	modport sink(input valid, input value, output ready);
endinterface

interface u2da_char_if;
	import u2da_pkg::*;
	logic valid;
	logic ready;
	logic [CHAR_W-1:0] digit_char;
	logic last_digit;
	modport source(output valid, output digit_char, output last_digit, input ready);
	modport sink(input valid, input digit_char, input last_digit, output ready);
endinterface

FILE: hdl/u2da_dabble_pipe.sv
// Four-stage double dabble pipeline from binary to packed BCD.
module u2da_dabble_pipe (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [u2da_pkg::VALUE_W-1:0] in_value,
	output logic out_valid,
	input  logic out_ready,
	output u2da_pkg::bcd_t out_bcd
);
	import u2da_pkg::*;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	dd_t dd_s1, dd_s2, dd_s3, dd_s4;
	logic adv_s1, adv_s2, adv_s3, adv_s4;

	// A stage takes new data when it is empty or its contents move on.
	assign adv_s4 = !valid_s4 || out_ready;
	assign adv_s3 = !valid_s3 || adv_s4;
	assign adv_s2 = !valid_s2 || adv_s3;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= in_valid;
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s3) valid_s3 <= valid_s2;
			if (adv_s4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) dd_s1 <= dabble_steps('{bcd: '0, bin: in_value});
		if (adv_s2) dd_s2 <= dabble_steps(dd_s1);
		if (adv_s3) dd_s3 <= dabble_steps(dd_s2);
		if (adv_s4) dd_s4 <= dabble_steps(dd_s3);
	end

	assign out_valid = valid_s4;
	assign out_bcd = dd_s4.bcd;

endmodule

FILE: hdl/u2da_emitter.sv
// Serializes one BCD number into ASCII digits, most significant first.
module u2da_emitter (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  u2da_pkg::bcd_t in_bcd,
	output logic out_valid,
	input  logic out_ready,
	output logic [u2da_pkg::CHAR_W-1:0] digit_char,
	output logic last_digit
);
	import u2da_pkg::*;

	logic busy_q;
	bcd_t digits_q;
	digit_idx_t idx_q;
	logic at_last;
	logic load;

	assign at_last = (idx_q == '0);
	assign in_ready = !busy_q || (out_ready && at_last);
	assign load = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (load) begin
			busy_q <= 1'b1;
		end else if (busy_q && out_ready && at_last) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			digits_q <= in_bcd;
			idx_q <= top_digit_index(in_bcd);
		end else if (busy_q && out_ready && !at_last) begin
			idx_q <= idx_q - 1'b1;
		end
	end

	assign out_valid = busy_q;
	assign digit_char = ASCII_ZERO + {{(CHAR_W-NIBBLE_W){1'b0}}, digits_q[idx_q]};
	assign last_digit = at_last;

endmodule

FILE: hdl/unsigned_to_decimal_ascii.sv
// Top level of the unsigned 16-bit to decimal ASCII converter.
// Each number transfer on the number channel yields its decimal text on the
// character channel: one transfer per digit, most significant digit first,
// no leading zeros, and zero gives the single character '0'. The transfer
// of the least significant digit carries last_digit high. A number passes a
// four-stage double dabble pipeline (four shift-and-add-3 steps per stage)
// and then reaches the digit emitter, which registers it before offering
// its first character. The emitter sends one character per cycle while the
// character channel is ready, one transfer per digit, one to five digits,
// and accepts the next number as the last digit of the current one
// transfers. The pipeline keeps accepting numbers while the emitter works
// and holds up to four of them; back pressure reaches the number channel
// only when all stages are full. No state is kept from one number to the
// next.
module unsigned_to_decimal_ascii (
	input logic clk,
	input logic arst_n,
	u2da_num_if.sink number,
	u2da_char_if.source text
);
	import u2da_pkg::*;

	logic bcd_valid;
	logic bcd_ready;
	bcd_t bcd;

	// Binary to BCD conversion.
	u2da_dabble_pipe u_pipe (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(number.valid),
		.in_ready(number.ready),
		.in_value(number.value),
		.out_valid(bcd_valid),
		.out_ready(bcd_ready),
		.out_bcd(bcd)
	);

	// Leading zero suppression and one character per transfer.
	u2da_emitter u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(bcd_valid),
		.in_ready(bcd_ready),
		.in_bcd(bcd),
		.out_valid(text.valid),
		.out_ready(text.ready),
		.digit_char(text.digit_char),
		.last_digit(text.last_digit)
	);

endmodule

FILE: hdl/u2da_checker.sv
// Port-level checker of the decimal ASCII converter and its bind.
`include "unsigned_to_decimal_ascii_assert.svh"

module u2da_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [u2da_pkg::CHAR_W-1:0] digit_char,
	input logic last_digit
);
	import u2da_pkg::*;

	logic first_q;
	logic [DIGIT_IDX_W-1:0] count_q;
	logic xfer;

	assign xfer = out_valid && out_ready;

	// Tracks the start of a run and the number of digits sent in it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
			count_q <= '0;
		end else if (xfer) begin
			first_q <= last_digit;
			count_q <= last_digit ? '0 : count_q + 1'b1;
		end
	end

	`U2DA_ASSERT_ALWAYS(a_char_is_digit, clk, arst_n, !out_valid || (digit_char >= ASCII_ZERO && digit_char <= ASCII_ZERO + CHAR_W'(9)))
	`U2DA_ASSERT_ALWAYS(a_no_leading_zero, clk, arst_n, !(out_valid && first_q && digit_char == ASCII_ZERO) || last_digit)
	`U2DA_ASSERT_ALWAYS(a_run_length, clk, arst_n, !out_valid || count_q < DIGIT_IDX_W'(DIGITS - 1) || last_digit)
	`U2DA_ASSERT_NEXT(a_stall_holds, clk, arst_n, out_valid && !out_ready, out_valid && $stable(digit_char) && $stable(last_digit))

endmodule

bind unsigned_to_decimal_ascii u2da_checker u_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(text.valid),
	.out_ready(text.ready),
	.digit_char(text.digit_char),
	.last_digit(text.last_digit)
);
